// ===== rtl/pattern_span_finder_top_defines.svh =====
// Assertion macros used by the top-level RTL file of the pattern span finder.
`ifndef PATTERN_SPAN_FINDER_TOP_DEFINES_SVH
`define PATTERN_SPAN_FINDER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks that prop holds at every clock edge outside reset.
`define PSF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checks that cond never holds outside reset.
`define PSF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PSF_ASSERT(lbl, clk, rstn, prop, msg)
`define PSF_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/psf_pkg.sv =====
package psf_pkg;

    localparam int MAX_PATTERN   = 8;
    localparam int POSITION_BITS = 16;

    // The pattern register holds eight bytes; bytes beyond it read as zero.
    localparam int PAT_BYTES  = 8;
    localparam int PAT_W      = 8 * PAT_BYTES;
    localparam int CFG_LEN_W  = 4;
    localparam int LEN_W      = $clog2(MAX_PATTERN + 1);

    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 64;

    // Register select is paddr[3] (registers sit at 8-byte strides).
    localparam logic REG_PATTERN = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic                     match_hit;
        logic [POSITION_BITS-1:0] match_begin;
        logic [POSITION_BITS-1:0] match_end;
        logic [POSITION_BITS-1:0] match_total;
        logic                     text_done;
        logic                     any_found;
    } t_out;

    typedef struct packed {
        logic [PAT_W-1:0]     pattern;
        logic [CFG_LEN_W-1:0] length;
    } t_cfg;

endpackage

// ===== rtl/psf_cfg.sv =====
module psf_cfg
    import psf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [PAT_W-1:0]     r_pattern;
    logic [CFG_LEN_W-1:0] r_length;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= CFG_LEN_W'(1);
        end else if (wr_en) begin
            unique case (paddr[3])
                REG_PATTERN: r_pattern <= pwdata[PAT_W-1:0];
                REG_LENGTH:  r_length  <= pwdata[CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_PATTERN: prdata = PDATA_W'(r_pattern);
            REG_LENGTH:  prdata = PDATA_W'(r_length);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.pattern = r_pattern;
    assign o_cfg.length  = r_length;

endmodule

// ===== rtl/psf_core.sv =====
module psf_core
    import psf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_step,
    input  t_in  i_item,
    output t_out o_result
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [7:0]               r_window [MAX_PATTERN];
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_prev_end;
    logic                     r_have_prev;
    logic [POSITION_BITS-1:0] r_count;

    logic [7:0]               n_window [MAX_PATTERN];
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] n_prev_end;
    logic                     n_have_prev;
    logic [POSITION_BITS-1:0] n_count;

    logic [LEN_W-1:0]         eff_len;
    logic [MAX_PATTERN-1:0]   lane_ok;
    logic                     pos_ok;
    logic                     hit;
    logic [POSITION_BITS-1:0] begin_pos;

    function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat, input int j);
        logic [7:0] b;
        b = '0;
        if (j >= 0 && j < PAT_BYTES) begin
            b = pat[8*j +: 8];
        end
        return b;
    endfunction

    // Length zero acts as one; anything above the window acts as the window size.
    always_comb begin
        if (i_cfg.length == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(i_cfg.length) > MAX_PATTERN) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = LEN_W'(i_cfg.length);
        end
    end

    always_comb begin
        n_window[0] = i_item.text_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    // Window slot k holds the byte k places back, which lines up with
    // pattern byte len-1-k.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            lane_ok[k] = (k >= int'(eff_len))
                      || (n_window[k] == pat_byte(i_cfg.pattern, int'(eff_len) - 1 - k));
        end
    end

    always_comb begin
        pos_ok    = (r_pos != POS_MAX)
                 && (({1'b0, r_pos} + (POSITION_BITS+1)'(1))
                     >= (POSITION_BITS+1)'(eff_len));
        begin_pos = r_pos + POSITION_BITS'(1) - POSITION_BITS'(eff_len);
        hit       = pos_ok && (&lane_ok) && (!r_have_prev || begin_pos > r_prev_end);

        n_pos       = (r_pos != POS_MAX) ? r_pos + POSITION_BITS'(1) : r_pos;
        n_prev_end  = hit ? r_pos : r_prev_end;
        n_have_prev = r_have_prev || hit;
        n_count     = (hit && r_count != POS_MAX) ? r_count + POSITION_BITS'(1) : r_count;
    end

    assign o_result.match_hit   = hit;
    assign o_result.match_begin = hit ? begin_pos : '0;
    assign o_result.match_end   = hit ? r_pos : '0;
    assign o_result.match_total = n_count;
    assign o_result.text_done   = i_item.final_byte;
    assign o_result.any_found   = (n_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= '0;
            end
            r_pos       <= '0;
            r_prev_end  <= '0;
            r_have_prev <= 1'b0;
            r_count     <= '0;
        end else if (i_step) begin
            if (i_item.final_byte) begin
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_window[k] <= '0;
                end
                r_pos       <= '0;
                r_prev_end  <= '0;
                r_have_prev <= 1'b0;
                r_count     <= '0;
            end else begin
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_window[k] <= n_window[k];
                end
                r_pos       <= n_pos;
                r_prev_end  <= n_prev_end;
                r_have_prev <= n_have_prev;
                r_count     <= n_count;
            end
        end
    end

endmodule

// ===== rtl/pattern_span_finder_top.sv =====
// Streaming pattern search: text bytes enter one beat per cycle and every
// input beat yields exactly one result beat. A beat is first captured in an
// input register; once the result register is empty or drains, the byte
// window is compared with the pattern in parallel and the result is loaded
// into the result register, so a new byte is taken every cycle as long as
// the result register drains. Patterns of 1 to 8 bytes are set through the
// APB registers (pattern bytes at address 0, length at address 8), which
// should only be written while no beats are in flight. Positions and counts
// saturate at 65535, and the search restarts at position zero after each
// beat flagged as the final byte of a text.
`include "pattern_span_finder_top_defines.svh"

module pattern_span_finder_top
    import psf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg cfg;
    t_out result;

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;

    logic advance;
    logic in_take;

    psf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    psf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    // The held beat moves on whenever the result register is empty or drains.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PSF_ASSERT(a_span_len, i_clk, i_rst_n, (r_out_valid && r_out.match_hit) |-> (r_out.match_end - r_out.match_begin == POSITION_BITS'(u_core.eff_len) - POSITION_BITS'(1)), "match span does not equal pattern length")
    `PSF_ASSERT(a_miss_zero, i_clk, i_rst_n, (r_out_valid && !r_out.match_hit) |-> (r_out.match_begin == '0 && r_out.match_end == '0), "miss result carries a nonzero span")
    `PSF_ASSERT(a_any_found, i_clk, i_rst_n, r_out_valid |-> (r_out.any_found == (r_out.match_total != '0)), "any_found disagrees with match_total")
    `PSF_ASSERT_NEVER(a_stall_empty, i_clk, i_rst_n, o_in_stall && !r_in_valid, "input stalled with empty input register")
    `PSF_ASSERT(a_hold_result, i_clk, i_rst_n, (r_out_valid && i_out_stall && r_in_valid) |=> (r_in_valid && r_out_valid), "beat lost while output stalled")

endmodule

// ===== bench/psf_span_checker.sv =====
`timescale 1ns / 1ps

module psf_span_checker
    import psf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in                i_in,

    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out               i_out,

    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic               i_pready,

    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int unsigned POS_MAX = (1 << POSITION_BITS) - 1;

    // Shadow copy of the registers and of the per-text search state.
    logic [PAT_W-1:0]     cfg_pattern = '0;
    logic [CFG_LEN_W-1:0] cfg_length  = CFG_LEN_W'(1);
    logic [7:0]           window [MAX_PATTERN];
    int unsigned          text_pos;
    int unsigned          prev_end;
    int unsigned          hit_count;
    logic                 have_prev;

    t_out span_q [$];
    int   fails = 0;

    task automatic clear_text();
        for (int k = 0; k < MAX_PATTERN; k++) begin
            window[k] = 8'h00;
        end
        text_pos  = 0;
        prev_end  = 0;
        hit_count = 0;
        have_prev = 1'b0;
    endtask

    // Shifts one byte into the window and works out the span it completes.
    task automatic scan_byte(input t_in beat, output t_out res);
        int unsigned plen;
        int unsigned start;
        logic [7:0]  pat_k;
        logic        same;
        plen = 32'(cfg_length);
        if (plen == 0) begin
            plen = 1;
        end
        if (plen > MAX_PATTERN) begin
            plen = MAX_PATTERN;
        end
        for (int k = MAX_PATTERN - 1; k > 0; k--) begin
            window[k] = window[k-1];
        end
        window[0] = beat.text_byte;
        res = '0;
        if (text_pos < POS_MAX && text_pos + 1 >= plen) begin
            same = 1'b1;
            for (int k = 0; k < plen; k++) begin
                pat_k = (k < PAT_BYTES) ? cfg_pattern[8*k +: 8] : 8'h00;
                if (window[plen-1-k] != pat_k) begin
                    same = 1'b0;
                end
            end
            start = text_pos + 1 - plen;
            // A span must start strictly after the previous one ended.
            if (same && (!have_prev || start > prev_end)) begin
                res.match_hit   = 1'b1;
                res.match_begin = start[POSITION_BITS-1:0];
                res.match_end   = text_pos[POSITION_BITS-1:0];
                prev_end        = text_pos;
                have_prev       = 1'b1;
                if (hit_count < POS_MAX) begin
                    hit_count++;
                end
            end
        end
        if (text_pos < POS_MAX) begin
            text_pos++;
        end
        res.match_total = hit_count[POSITION_BITS-1:0];
        res.text_done   = beat.final_byte;
        res.any_found   = (hit_count != 0);
        if (beat.final_byte) begin
            clear_text();
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fails++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            cfg_pattern = '0;
            cfg_length  = CFG_LEN_W'(1);
            clear_text();
            span_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[PADDR_W-1] == REG_LENGTH) begin
                    cfg_length = i_pwdata[CFG_LEN_W-1:0];
                end else begin
                    cfg_pattern = i_pwdata[PAT_W-1:0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (span_q.size() == 0) begin
                    fails++;
                    $error("result beat arrived with no expected span waiting");
                end else begin
                    want = span_q.pop_front();
                    check_field("match_hit",   32'(want.match_hit),   32'(i_out.match_hit));
                    check_field("match_begin", 32'(want.match_begin), 32'(i_out.match_begin));
                    check_field("match_end",   32'(want.match_end),   32'(i_out.match_end));
                    check_field("match_total", 32'(want.match_total), 32'(i_out.match_total));
                    check_field("text_done",   32'(want.text_done),   32'(i_out.text_done));
                    check_field("any_found",   32'(want.any_found),   32'(i_out.any_found));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                scan_byte(i_in, want);
                span_q.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= span_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import psf_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_PATTERN = {REG_PATTERN, 3'b000};
    localparam logic [PADDR_W-1:0] ADDR_LENGTH  = {REG_LENGTH, 3'b000};
    localparam int LONG_TEXT   = 40;
    localparam int HOLD_CYCLES = 300;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;

    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in                in_beat   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out               out_beat;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_tog  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    logic [PAT_W-1:0] cur_pattern = '0;
    int               cur_length  = 1;

    pattern_span_finder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    psf_span_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_beat),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen = hold_tog;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic send_beat(input logic [7:0] text, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{text_byte: text, final_byte: last};
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_pattern(input logic [PAT_W-1:0] pat, input int len);
        cfg_write(ADDR_PATTERN, PDATA_W'(pat));
        cfg_write(ADDR_LENGTH, PDATA_W'(len));
        cur_pattern = pat;
        cur_length  = len;
    endtask

    // Mostly copies of the pattern and its bytes shuffled, so that full,
    // partial and overlapping matches are common; the rest is noise.
    task automatic send_phase(input int count);
        int n;
        int sel;
        int plen;
        plen = cur_length;
        if (plen == 0) begin
            plen = 1;
        end
        if (plen > MAX_PATTERN) begin
            plen = MAX_PATTERN;
        end
        n = 0;
        while (n < count) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                for (int k = 0; k < plen; k++) begin
                    send_beat(cur_pattern[8*k +: 8], ($urandom_range(29) == 0));
                    n++;
                end
            end else if (sel < 90) begin
                send_beat(cur_pattern[8*$urandom_range(plen-1) +: 8], ($urandom_range(29) == 0));
                n++;
            end else begin
                send_beat(8'($urandom_range(255)), ($urandom_range(29) == 0));
                n++;
            end
        end
    endtask

    function automatic logic [PAT_W-1:0] small_alphabet_pattern();
        logic [PAT_W-1:0] pat;
        int lo;
        int span;
        lo   = $urandom_range(255);
        span = $urandom_range(1, 3);
        for (int k = 0; k < PAT_BYTES; k++) begin
            pat[8*k +: 8] = 8'(lo + $urandom_range(span - 1));
        end
        return pat;
    endfunction

    initial begin
        int len;
        logic [PAT_W-1:0] pat;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 34;
        rx_idle_pct = 34;

        // Register values after reset: pattern of one zero byte.
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        wait_drain();

        // Length above the maximum behaves as eight; the ninth byte overlaps.
        set_pattern('1, 15);
        for (int k = 0; k < 9; k++) begin
            send_beat(8'hFF, k == 8);
        end
        wait_drain();

        // Length zero behaves as one.
        set_pattern(64'h41, 0);
        send_beat(8'h41, 1'b0);
        send_beat(8'h41, 1'b1);
        wait_drain();

        // Overlapping candidates: only every second pair is reported.
        set_pattern(64'h4141, 2);
        for (int k = 0; k < 4; k++) begin
            send_beat(8'h41, k == 3);
        end
        wait_drain();

        // One text with no idling on either side.
        set_pattern(64'h5A, 1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int k = 0; k < LONG_TEXT; k++) begin
            send_beat(8'h5A, k == LONG_TEXT - 1);
        end
        wait_drain();

        // The result side holds off while beats keep coming, so the block fills.
        set_pattern(small_alphabet_pattern(), 3);
        tx_idle_pct = 0;
        rx_idle_pct = 34;
        hold_tog <= ~hold_tog;
        send_phase(60);
        wait_drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0:       len = 1;
                1:       len = 8;
                2:       len = 0;
                default: len = $urandom_range(15);
            endcase
            if (ph == 3) begin
                pat = {$urandom, $urandom};
            end else begin
                pat = small_alphabet_pattern();
            end
            set_pattern(pat, len);
            tx_idle_pct = (ph == 4) ? 0 : 34;
            rx_idle_pct = (ph == 4) ? 0 : 34;
            send_phase(100);
            wait_drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/psf_pkg.sv
rtl/psf_cfg.sv
rtl/psf_core.sv
rtl/pattern_span_finder_top.sv
bench/psf_span_checker.sv
bench/tb_top.sv
